[hw/rtl/tta_pkg.sv]
package tta_pkg;

    // width of the step counter of the shared unit (up to 127 steps)
    localparam int STEP_W = 7;

    // event codes carried in the mode field
    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_ELAPSED = 2'd3
    } tta_mode_t;

    // register indexes of the configuration write port
    localparam logic [1:0] CFG_CPT      = 2'd0;
    localparam logic [1:0] CFG_MAX      = 2'd1;
    localparam logic [1:0] CFG_TICKLESS = 2'd2;

    // operation of the shared unit
    typedef enum logic [0:0] {
        UOP_DIV = 1'b0,
        UOP_MUL = 1'b1
    } tta_uop_t;

    // request to the shared unit
    typedef struct packed {
        logic              start;
        tta_uop_t          op;
        logic [STEP_W-1:0] steps;
        logic [63:0]       a;
        logic [31:0]       b;
    } tta_unit_req_t;

    // status of the shared unit
    typedef struct packed {
        logic busy;
        logic done;
    } tta_unit_stat_t;

endpackage

[hw/rtl/tickless_tick_accounting.sv]
// Tick bookkeeping for a tickless system timer on a 64-bit free-running
// cycle counter. Each input word is one event (start, timer interrupt, set
// timeout, elapsed query) and gives exactly one result word. All divisions
// by cycles_per_tick and all multiplications by it run on one shared
// bit-serial unit: a divide makes one quotient bit per cycle over the full
// counter for start and DIFF_WIDTH bits of elapsed cycles otherwise, and a
// multiply steps through the bits of cycles_per_tick. Start and interrupt
// divide, then multiply; a periodic interrupt then re-arms; in tickless
// mode a finite timeout multiplies and clamps and a query divides; other
// events need no arithmetic. s_ready is high only while the sequencer is
// idle; a finished result waits in the output register while the next word
// is taken. The user must write configuration through cfg_wr_en, cfg_index
// and cfg_wr_data only while the block idles; no logic enforces this.
module tickless_tick_accounting #(
    parameter int DIFF_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_mode,
    input  logic [63:0]        s_now_cycles,
    input  logic signed [31:0] s_request_ticks,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_compare_write,
    output logic [63:0]        m_compare_value,
    output logic [31:0]        m_ticks_out
);

    localparam logic [31:0] CPT_RESET = 32'd3200;
    localparam logic [31:0] MAX_RESET = 32'd3221225472;

    localparam int DIFF_SHIFT = 64 - DIFF_WIDTH;
    localparam logic [tta_pkg::STEP_W-1:0] DIFF_STEPS = tta_pkg::STEP_W'(DIFF_WIDTH);
    localparam logic [tta_pkg::STEP_W-1:0] FULL_STEPS = tta_pkg::STEP_W'(64);
    localparam logic [tta_pkg::STEP_W-1:0] MUL_STEPS  = tta_pkg::STEP_W'(32);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIV    = 6'b000010,
        ST_MUL    = 6'b000100,
        ST_REARM  = 6'b001000,
        ST_CLAMP  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    tta_pkg::tta_mode_t  mode_reg, mode_next;
    logic [31:0] cpt_reg, cpt_next;
    logic [31:0] max_reg, max_next;
    logic        tickless_reg, tickless_next;
    logic [63:0] boundary_reg, boundary_next;
    logic [63:0] announced_reg, announced_next;
    logic [31:0] reported_reg, reported_next;
    logic        res_wr_reg, res_wr_next;
    logic [63:0] res_cmp_reg, res_cmp_next;
    logic [31:0] res_tk_reg, res_tk_next;
    logic        m_valid_reg, m_valid_next;
    logic        m_wr_reg, m_wr_next;
    logic [63:0] m_cmp_reg, m_cmp_next;
    logic [31:0] m_tk_reg, m_tk_next;

    tta_pkg::tta_unit_req_t  ureq;
    tta_pkg::tta_unit_stat_t ustat;
    logic [63:0]             uresult;

    logic [31:0] cpt;
    logic [63:0] req_sext;
    logic [63:0] since;
    logic [63:0] cmp_dist;
    logic        fire;

    tta_mul_div u_mul_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ureq),
        .stat    (ustat),
        .result  (uresult)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign fire     = s_valid && s_ready;
    assign cpt      = (cpt_reg == 32'd0) ? 32'd1 : cpt_reg;
    assign req_sext = {{32{s_request_ticks[31]}}, s_request_ticks};
    // cycles since the boundary, cut and left-aligned for the divider
    assign since    = (s_now_cycles - boundary_reg) << DIFF_SHIFT;
    assign cmp_dist = res_cmp_reg - boundary_reg;

    // configuration writes
    always_comb begin
        cpt_next      = cpt_reg;
        max_next      = max_reg;
        tickless_next = tickless_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                tta_pkg::CFG_CPT:      cpt_next      = cfg_wr_data;
                tta_pkg::CFG_MAX:      max_next      = cfg_wr_data;
                tta_pkg::CFG_TICKLESS: tickless_next = cfg_wr_data[0];
                default:      ;
            endcase
        end
    end

    // event sequencer
    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        boundary_next  = boundary_reg;
        announced_next = announced_reg;
        reported_next  = reported_reg;
        res_wr_next    = res_wr_reg;
        res_cmp_next   = res_cmp_reg;
        res_tk_next    = res_tk_reg;
        m_valid_next   = m_valid_reg;
        m_wr_next      = m_wr_reg;
        m_cmp_next     = m_cmp_reg;
        m_tk_next      = m_tk_reg;
        ureq           = '0;
        ureq.b         = cpt;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (fire) begin
                    mode_next    = tta_pkg::tta_mode_t'(s_mode);
                    res_wr_next  = 1'b0;
                    res_cmp_next = '0;
                    res_tk_next  = '0;
                    state_next   = ST_FINISH;
                    case (tta_pkg::tta_mode_t'(s_mode))
                        tta_pkg::MODE_START: begin
                            ureq.start = 1'b1;
                            ureq.op    = tta_pkg::UOP_DIV;
                            ureq.steps = FULL_STEPS;
                            ureq.a     = s_now_cycles;
                            state_next = ST_DIV;
                        end
                        tta_pkg::MODE_TICK: begin
                            ureq.start = 1'b1;
                            ureq.op    = tta_pkg::UOP_DIV;
                            ureq.steps = DIFF_STEPS;
                            ureq.a     = since;
                            state_next = ST_DIV;
                        end
                        tta_pkg::MODE_TIMEOUT: begin
                            if (tickless_reg) begin
                                if (&s_request_ticks) begin
                                    // forever: farthest allowed compare
                                    res_wr_next  = 1'b1;
                                    res_cmp_next = boundary_reg + {32'd0, max_reg};
                                end else begin
                                    ureq.start = 1'b1;
                                    ureq.op    = tta_pkg::UOP_MUL;
                                    ureq.steps = MUL_STEPS;
                                    ureq.a     = announced_reg + {32'd0, reported_reg}
                                                 + req_sext;
                                    state_next = ST_MUL;
                                end
                            end
                        end
                        tta_pkg::MODE_ELAPSED: begin
                            if (tickless_reg) begin
                                ureq.start = 1'b1;
                                ureq.op    = tta_pkg::UOP_DIV;
                                ureq.steps = DIFF_STEPS;
                                ureq.a     = since;
                                state_next = ST_DIV;
                            end
                        end
                        default: state_next = ST_FINISH;
                    endcase
                end
            end
            ST_DIV: begin
                if (ustat.done) begin
                    case (mode_reg)
                        tta_pkg::MODE_START: begin
                            announced_next = uresult;
                            ureq.start     = 1'b1;
                            ureq.op        = tta_pkg::UOP_MUL;
                            ureq.steps     = MUL_STEPS;
                            ureq.a         = uresult;
                            state_next     = ST_MUL;
                        end
                        tta_pkg::MODE_TICK: begin
                            announced_next = announced_reg + {32'd0, uresult[31:0]};
                            reported_next  = '0;
                            res_tk_next    = uresult[31:0];
                            ureq.start     = 1'b1;
                            ureq.op        = tta_pkg::UOP_MUL;
                            ureq.steps     = MUL_STEPS;
                            ureq.a         = {32'd0, uresult[31:0]};
                            state_next     = ST_MUL;
                        end
                        default: begin
                            reported_next = uresult[31:0];
                            res_tk_next   = uresult[31:0];
                            state_next    = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                if (ustat.done) begin
                    case (mode_reg)
                        tta_pkg::MODE_START: begin
                            boundary_next = uresult;
                            res_wr_next   = 1'b1;
                            res_cmp_next  = uresult + {32'd0, cpt};
                            state_next    = ST_FINISH;
                        end
                        tta_pkg::MODE_TICK: begin
                            boundary_next = boundary_reg + uresult;
                            state_next    = tickless_reg ? ST_FINISH : ST_REARM;
                        end
                        default: begin
                            res_cmp_next = uresult;
                            state_next   = ST_CLAMP;
                        end
                    endcase
                end
            end
            ST_REARM: begin
                // periodic mode: next compare one tick past the new boundary
                res_wr_next  = 1'b1;
                res_cmp_next = boundary_reg + {32'd0, cpt};
                state_next   = ST_FINISH;
            end
            ST_CLAMP: begin
                // limit the compare distance from the boundary
                res_wr_next = 1'b1;
                if (cmp_dist > {32'd0, max_reg}) begin
                    res_cmp_next = boundary_reg + {32'd0, max_reg};
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_wr_next    = res_wr_reg;
                    m_cmp_next   = res_cmp_reg;
                    m_tk_next    = res_tk_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control and bookkeeping registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= tta_pkg::MODE_START;
            cpt_reg       <= CPT_RESET;
            max_reg       <= MAX_RESET;
            tickless_reg  <= 1'b1;
            boundary_reg  <= '0;
            announced_reg <= '0;
            reported_reg  <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            cpt_reg       <= cpt_next;
            max_reg       <= max_next;
            tickless_reg  <= tickless_next;
            boundary_reg  <= boundary_next;
            announced_reg <= announced_next;
            reported_reg  <= reported_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        res_wr_reg  <= res_wr_next;
        res_cmp_reg <= res_cmp_next;
        res_tk_reg  <= res_tk_next;
        m_wr_reg    <= m_wr_next;
        m_cmp_reg   <= m_cmp_next;
        m_tk_reg    <= m_tk_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_compare_write = m_wr_reg;
    assign m_compare_value = m_cmp_reg;
    assign m_ticks_out     = m_tk_reg;

endmodule

[hw/rtl/tta_mul_div.sv]
module tta_mul_div (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tta_pkg::tta_unit_req_t req,
    output tta_pkg::tta_unit_stat_t stat,
    output logic [63:0]            result
);

    tta_pkg::tta_uop_t          op_reg, op_next;
    logic [tta_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [63:0]                sh_reg, sh_next;
    logic [63:0]                acc_reg, acc_next;
    logic [31:0]                b_reg, b_next;

    logic [32:0] part;
    logic [33:0] diff;
    logic [63:0] sum;

    // one restoring divide step or one shift-add multiply step per cycle
    always_comb begin
        part      = {acc_reg[31:0], sh_reg[63]};
        diff      = {1'b0, part} - {2'b00, b_reg};
        sum       = acc_reg + sh_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        if (req.start) begin
            op_next   = req.op;
            cnt_next  = req.steps;
            busy_next = 1'b1;
            sh_next   = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (op_reg == tta_pkg::UOP_DIV) begin
                if (!diff[33]) begin
                    acc_next = {32'd0, diff[31:0]};
                    sh_next  = {sh_reg[62:0], 1'b1};
                end else begin
                    acc_next = {32'd0, part[31:0]};
                    sh_next  = {sh_reg[62:0], 1'b0};
                end
            end else begin
                if (b_reg[0]) begin
                    acc_next = sum;
                end
                sh_next = {sh_reg[62:0], 1'b0};
                b_next  = {1'b0, b_reg[31:1]};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tta_pkg::STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= tta_pkg::UOP_DIV;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        sh_reg  <= sh_next;
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    // quotient sits in the shift register, product in the accumulator
    assign result    = (op_reg == tta_pkg::UOP_DIV) ? sh_reg : acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    // a new operation only starts on an idle unit
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("unit started while busy");

    // start always makes the unit busy
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("unit not busy after start");

    // done is a single pulse and comes with the unit idle
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg ##1 !done_reg || req.start)
        else $error("done not a single pulse");

    // partial remainder stays below the divisor
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && op_reg == tta_pkg::UOP_DIV |-> acc_reg[31:0] < b_reg)
        else $error("remainder out of range");

endmodule

[tb/sv/tb.sv]
module tb;

    localparam int DIFF_W = 32;

    localparam logic [31:0] FOREVER_TICKS = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        compare_write;
        logic [63:0] compare_value;
        logic [31:0] ticks_out;
    } timer_word_t;

    // tick bookkeeping mirror and queue of the compare/tick words it predicts
    class tick_ledger;
        logic [63:0] boundary;
        logic [63:0] announced;
        logic [31:0] reported;
        logic [31:0] tick_len;
        logic [31:0] max_span;
        logic        tickless;
        timer_word_t due_words[$];
        int          errors;

        function new();
            boundary  = '0;
            announced = '0;
            reported  = '0;
            tick_len  = 32'd3200;
            max_span  = 32'd3221225472;
            tickless  = 1'b1;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                tta_pkg::CFG_CPT:      tick_len = data;
                tta_pkg::CFG_MAX:      max_span = data;
                tta_pkg::CFG_TICKLESS: tickless = data[0];
                default: ;
            endcase
        endfunction

        function logic [63:0] eff_len();
            return (tick_len == 32'd0) ? 64'd1 : {32'd0, tick_len};
        endfunction

        // whole ticks since the boundary, elapsed cycles cut to DIFF_W bits
        function logic [31:0] ticks_since(logic [63:0] now);
            logic [63:0] diff;
            logic [63:0] quot;
            diff = now - boundary;
            if (DIFF_W < 64)
                diff = diff & ((64'd1 << DIFF_W) - 64'd1);
            quot = diff / eff_len();
            return quot[31:0];
        endfunction

        function void note_event(tta_pkg::tta_mode_t mode, logic [63:0] now,
                                 logic [31:0] req);
            logic [63:0] len;
            logic [63:0] cmp;
            logic [63:0] sreq;
            logic [31:0] dt;
            timer_word_t w;
            len = eff_len();
            w   = '0;
            case (mode)
                tta_pkg::MODE_START: begin
                    announced = now / len;
                    boundary  = announced * len;
                    w.compare_write = 1'b1;
                    w.compare_value = boundary + len;
                end
                tta_pkg::MODE_TICK: begin
                    dt = ticks_since(now);
                    boundary  = boundary + {32'd0, dt} * len;
                    announced = announced + {32'd0, dt};
                    reported  = '0;
                    w.ticks_out = dt;
                    // periodic mode re-arms one tick ahead
                    if (!tickless) begin
                        w.compare_write = 1'b1;
                        w.compare_value = boundary + len;
                    end
                end
                tta_pkg::MODE_TIMEOUT: begin
                    if (tickless) begin
                        if (req == FOREVER_TICKS) begin
                            cmp = boundary + {32'd0, max_span};
                        end else begin
                            sreq = {{32{req[31]}}, req};
                            cmp  = (announced + {32'd0, reported} + sreq) * len;
                            if (cmp - boundary > {32'd0, max_span})
                                cmp = boundary + {32'd0, max_span};
                        end
                        w.compare_write = 1'b1;
                        w.compare_value = cmp;
                    end
                end
                default: begin
                    if (tickless) begin
                        dt = ticks_since(now);
                        reported    = dt;
                        w.ticks_out = dt;
                    end
                end
            endcase
            due_words.push_back(w);
        endfunction

        function void check_result(logic cw, logic [63:0] cv, logic [31:0] tk);
            timer_word_t w;
            if (due_words.size() == 0) begin
                $error("result word with none expected: compare_write %0d value %0h ticks %0d",
                       cw, cv, tk);
                errors++;
                return;
            end
            w = due_words.pop_front();
            if (cw !== w.compare_write) begin
                $error("compare_write: expected %0d, actual %0d", w.compare_write, cw);
                errors++;
            end
            if (cv !== w.compare_value) begin
                $error("compare_value: expected %0h, actual %0h", w.compare_value, cv);
                errors++;
            end
            if (tk !== w.ticks_out) begin
                $error("ticks_out: expected %0d, actual %0d", w.ticks_out, tk);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn         = 1'b0;
    logic               cfg_wr_en       = 1'b0;
    logic [1:0]         cfg_index       = '0;
    logic [31:0]        cfg_wr_data     = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [1:0]         s_mode          = '0;
    logic [63:0]        s_now_cycles    = '0;
    logic signed [31:0] s_request_ticks = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic               m_compare_write;
    logic [63:0]        m_compare_value;
    logic [31:0]        m_ticks_out;

    int send_idle_pct = 27;
    int recv_idle_pct = 67;

    tick_ledger ledger;

    tickless_tick_accounting #(
        .DIFF_WIDTH(DIFF_W)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_now_cycles   (s_now_cycles),
        .s_request_ticks(s_request_ticks),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_compare_write(m_compare_write),
        .m_compare_value(m_compare_value),
        .m_ticks_out    (m_ticks_out)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            ledger.check_result(m_compare_write, m_compare_value, m_ticks_out);
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // wait until every predicted word has come back, then let the block settle
    task automatic wait_drained();
        while (ledger.due_words.size() != 0) @(posedge aclk);
        repeat (120) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        ledger.set_reg(idx, data);
    endtask

    task automatic configure(input logic [31:0] len, input logic [31:0] span, input logic tl);
        wait_drained();
        write_reg(tta_pkg::CFG_CPT, len);
        write_reg(tta_pkg::CFG_MAX, span);
        write_reg(tta_pkg::CFG_TICKLESS, {31'd0, tl});
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_word(input tta_pkg::tta_mode_t mode, input logic [63:0] now,
                             input logic [31:0] req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_now_cycles    <= now;
        s_request_ticks <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ledger.note_event(mode, now, req);
    endtask

    // counter value near the boundary half of the time, up to a 32-bit span past it or noise otherwise
    function automatic logic [63:0] pick_now();
        logic [63:0] len;
        int          sel;
        len = ledger.eff_len();
        sel = $urandom_range(99);
        if (sel < 10)
            return {$urandom, $urandom};
        else if (sel < 20)
            return ledger.boundary - 64'($urandom_range(5000, 1));
        else if (sel < 60)
            return ledger.boundary + len * 64'($urandom_range(40)) + 64'($urandom_range(3));
        else
            return ledger.boundary + {32'd0, $urandom};
    endfunction

    function automatic logic [31:0] pick_request();
        int sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return FOREVER_TICKS;
        else if (sel < 25)
            return $urandom;
        else if (sel < 35)
            return 32'd0 - 32'($urandom_range(20, 2));
        else
            return 32'($urandom_range(60));
    endfunction

    task automatic run_random(input int count);
        int                 sel;
        tta_pkg::tta_mode_t mode;
        logic [63:0]        now;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 8)
                mode = tta_pkg::MODE_START;
            else if (sel < 38)
                mode = tta_pkg::MODE_TICK;
            else if (sel < 70)
                mode = tta_pkg::MODE_TIMEOUT;
            else
                mode = tta_pkg::MODE_ELAPSED;
            if (mode == tta_pkg::MODE_START)
                now = ($urandom_range(3) == 0) ? 64'($urandom_range(100000))
                                               : {$urandom, $urandom};
            else
                now = pick_now();
            send_word(mode, now, pick_request());
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0] len;
        logic [31:0] span;
        logic        tl;
        ledger = new();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset settings, tickless
        send_word(tta_pkg::MODE_START, 64'd0, 32'd0);
        send_word(tta_pkg::MODE_ELAPSED, 64'd0, 32'd0);
        send_word(tta_pkg::MODE_ELAPSED, 64'd3200 * 5 + 7, 32'd0);
        send_word(tta_pkg::MODE_TIMEOUT, {$urandom, $urandom}, 32'd3);
        send_word(tta_pkg::MODE_TIMEOUT, 64'd0, FOREVER_TICKS);
        send_word(tta_pkg::MODE_TIMEOUT, 64'd0, 32'h7FFF_FFFF);
        send_word(tta_pkg::MODE_TIMEOUT, 64'd0, 32'd0 - 32'd10);
        send_word(tta_pkg::MODE_TICK, 64'd3200 * 9 + 1, 32'd0);
        // counter behind the boundary wraps the cut difference
        send_word(tta_pkg::MODE_TICK, ledger.boundary - 64'd1, 32'd0);
        send_word(tta_pkg::MODE_START, '1, 32'd0);
        send_word(tta_pkg::MODE_ELAPSED, '1 + 64'd6400, 32'd0);
        send_word(tta_pkg::MODE_TICK, 64'd0, 32'd0);
        send_word(tta_pkg::MODE_TIMEOUT, 64'd0, 32'd0);
        s_valid <= 1'b0;

        // periodic re-arm
        configure(32'd3200, 32'd3221225472, 1'b0);
        send_word(tta_pkg::MODE_TICK, ledger.boundary + 64'd3200 * 4, 32'd0);
        send_word(tta_pkg::MODE_TIMEOUT, 64'd0, 32'd5);
        send_word(tta_pkg::MODE_ELAPSED, ledger.boundary + 64'd9000, 32'd0);
        send_word(tta_pkg::MODE_START, {$urandom, $urandom}, 32'd0);
        s_valid <= 1'b0;

        // zero tick length counts as one, span of one
        configure(32'd0, 32'd1, 1'b1);
        send_word(tta_pkg::MODE_START, 64'd12345, 32'd0);
        send_word(tta_pkg::MODE_TICK, 64'd12345 + 64'd1000, 32'd0);
        send_word(tta_pkg::MODE_TIMEOUT, 64'd0, 32'd7);
        send_word(tta_pkg::MODE_ELAPSED, ledger.boundary + 64'd77, 32'd0);
        s_valid <= 1'b0;

        // largest tick and span
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_word(tta_pkg::MODE_START, '1, 32'd0);
        send_word(tta_pkg::MODE_TIMEOUT, 64'd0, FOREVER_TICKS);
        s_valid <= 1'b0;

        // random phases over a spread of settings and idle patterns
        for (int p = 0; p < 9; p++) begin
            case (p)
                0: begin len = 32'd3200;           span = 32'd3221225472; tl = 1'b1; end
                1: begin len = 32'd1;              span = 32'd1;          tl = 1'b1; end
                2: begin len = 32'hFFFF_FFFF;      span = 32'hFFFF_FFFF;  tl = 1'b1; end
                3: begin len = 32'd1000;           span = 32'd50000;      tl = 1'b0; end
                4: begin len = $urandom_range(100000, 2); span = $urandom; tl = 1'b1; end
                5: begin len = 32'd7;              span = 32'hFFFF_FFFF;  tl = 1'b1; end
                6: begin len = 32'd0;              span = 32'd100;        tl = 1'b1; end
                7: begin
                    len  = $urandom_range(5000, 1);
                    span = $urandom_range(1000000, 1);
                    tl   = 1'($urandom_range(1));
                end
                default: begin len = 32'hFFFF_FFFF; span = 32'd1; tl = 1'b0; end
            endcase
            configure(len, span, tl);
            case (p / 3)
                0: begin send_idle_pct = 27; recv_idle_pct = 67; end
                1: begin send_idle_pct = 67; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            run_random(106);
        end

        wait_drained();
        if (ledger.due_words.size() != 0) begin
            $error("%0d result words never arrived", ledger.due_words.size());
            ledger.errors++;
        end
        if (ledger.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
